FILE: rtl/zsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsd_pkg
// Types, widths, register codes and reset values shared by the speed and
// direction estimator.
// ----------------------------------------------------------------------------
package zsd_pkg;

    localparam int ACC_WIDTH       = 16;
    localparam int SPEED_WIDTH     = 24;
    localparam int MAG_WIDTH       = 15;
    localparam int LEVEL_WIDTH     = 15;
    localparam int COUNT_WIDTH     = 8;
    localparam int GAIN_WIDTH      = 16;
    localparam int KMH_WIDTH       = 26;
    localparam int DIR_WIDTH       = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // shared multiplier
    localparam int MUL_WIDTH    = 32;
    localparam int FRAC_SHIFT   = 16;
    localparam int INC_WIDTH    = MAG_WIDTH + GAIN_WIDTH - FRAC_SHIFT;
    localparam int SCALED_WIDTH = SPEED_WIDTH + 5;

    // km/h = floor(speed * 18 / 5); divide by 5 as multiply by ceil(2^32 / 5)
    localparam logic [MUL_WIDTH-1:0] KMH_FACTOR  = MUL_WIDTH'(18);
    localparam logic [MUL_WIDTH-1:0] RECIP_FIVE  = MUL_WIDTH'(858993460);
    localparam int                   RECIP_SHIFT = 32;

    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = {SPEED_WIDTH{1'b1}};

    localparam logic [LEVEL_WIDTH-1:0] STATIONARY_LEVEL_RST = LEVEL_WIDTH'(205);
    localparam logic [COUNT_WIDTH-1:0] STILL_COUNT_LIMIT_RST = COUNT_WIDTH'(10);
    localparam logic [LEVEL_WIDTH-1:0] AXIS_LEVEL_RST       = LEVEL_WIDTH'(410);
    localparam logic [GAIN_WIDTH-1:0]  STEP_GAIN_RST        = GAIN_WIDTH'(6554);
    localparam logic [GAIN_WIDTH-1:0]  DAMPING_RST          = GAIN_WIDTH'(64225);

    typedef enum logic [DIR_WIDTH-1:0] {
        DIR_UNKNOWN  = 3'd0,
        DIR_FORWARD  = 3'd1,
        DIR_BACKWARD = 3'd2,
        DIR_LEFT     = 3'd3,
        DIR_RIGHT    = 3'd4
    } dir_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_STATIONARY_LEVEL  = 3'd0,
        CFG_STILL_COUNT_LIMIT = 3'd1,
        CFG_AXIS_LEVEL        = 3'd2,
        CFG_STEP_GAIN         = 3'd3,
        CFG_DAMPING           = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        [MAG_WIDTH-1:0] magnitude;
        logic signed [ACC_WIDTH-1:0] accel_x;
        logic signed [ACC_WIDTH-1:0] accel_y;
        logic                        sample_valid;
    } sample_t;

    typedef struct packed {
        logic [SPEED_WIDTH-1:0] speed_mps;
        logic [KMH_WIDTH-1:0]   speed_kmh;
        dir_t                   heading;
        logic                   is_stationary;
    } result_t;

endpackage

FILE: rtl/zupt_speed_direction_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zupt_speed_direction_estimator
// Zero velocity update speed integrator with dominant axis direction.
// ----------------------------------------------------------------------------
// One item is handled at a time. An invalid or quiet sample passes through the
// decide, scale, reciprocal and done states; a moving sample passes through
// decide, sum, damp, speed, scale, reciprocal and done. The next item is taken
// in the cycle after the result is registered. The sequence is set by one
// shared 32x32 multiplier that is used in sequence for the step gain, the
// damping, the times-18 and the divide-by-5 reciprocal. A result waits in an
// output register; the sequencer holds only if that register is still full.
// Configuration writes take effect at once and are meant for idle times.
// ----------------------------------------------------------------------------
module zupt_speed_direction_estimator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  zsd_pkg::sample_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output zsd_pkg::result_t                     out_data,
    input  logic                                 cfg_we,
    input  logic [zsd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [zsd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECIDE = 8'b0000_0010,
        ST_SUM    = 8'b0000_0100,
        ST_DAMP   = 8'b0000_1000,
        ST_SPEED  = 8'b0001_0000,
        ST_SCALE  = 8'b0010_0000,
        ST_RECIP  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    localparam int MW = zsd_pkg::MUL_WIDTH;
    localparam int AW = zsd_pkg::ACC_WIDTH;
    localparam int SW = zsd_pkg::SPEED_WIDTH;

    state_t state_reg, state_next;

    // configuration
    logic [zsd_pkg::LEVEL_WIDTH-1:0] stationary_level_reg;
    logic [zsd_pkg::COUNT_WIDTH-1:0] still_count_limit_reg;
    logic [zsd_pkg::LEVEL_WIDTH-1:0] axis_level_reg;
    logic [zsd_pkg::GAIN_WIDTH-1:0]  step_gain_reg;
    logic [zsd_pkg::GAIN_WIDTH-1:0]  damping_reg;

    // estimator state
    logic [SW-1:0]                   speed_reg, speed_next;
    zsd_pkg::dir_t                   dir_reg, dir_next;
    logic [zsd_pkg::COUNT_WIDTH-1:0] quiet_reg, quiet_next;
    logic                            stationary_reg, stationary_next;

    // working registers
    zsd_pkg::sample_t                smp_reg;
    logic [SW-1:0]                   sum_reg;
    zsd_pkg::result_t                out_data_reg;
    logic                            out_valid_reg;

    // shared multiplier
    logic                            mul_en;
    logic [MW-1:0]                   mul_a, mul_b;
    logic [2*MW-1:0]                 mul_p;

    zsd_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // sample decode
    logic                            is_quiet;
    logic [zsd_pkg::COUNT_WIDTH-1:0] quiet_inc;
    logic                            zero_hit;
    logic signed [AW:0]              x_ext, y_ext;
    logic [AW:0]                     abs_x, abs_y, level_ext;
    logic                            dir_hit;
    zsd_pkg::dir_t                   dir_new;
    logic [SW:0]                     sum_wide;
    logic [SW-1:0]                   sum_sat;
    logic                            accept_in;
    logic                            done_fire;

    assign accept_in = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        is_quiet  = smp_reg.magnitude < stationary_level_reg;
        quiet_inc = (quiet_reg < still_count_limit_reg) ? quiet_reg + 1'b1 : quiet_reg;
        zero_hit  = quiet_inc >= still_count_limit_reg;

        x_ext     = {smp_reg.accel_x[AW-1], smp_reg.accel_x};
        y_ext     = {smp_reg.accel_y[AW-1], smp_reg.accel_y};
        abs_x     = x_ext[AW] ? $unsigned(-x_ext) : $unsigned(x_ext);
        abs_y     = y_ext[AW] ? $unsigned(-y_ext) : $unsigned(y_ext);
        level_ext = (AW + 1)'(axis_level_reg);
        dir_hit   = (abs_x > level_ext) || (abs_y > level_ext);

        if (abs_x > abs_y)
        begin
            dir_new = (!x_ext[AW] && (|x_ext)) ? zsd_pkg::DIR_LEFT : zsd_pkg::DIR_RIGHT;
        end
        else
        begin
            dir_new = (!y_ext[AW] && (|y_ext)) ? zsd_pkg::DIR_FORWARD
                                               : zsd_pkg::DIR_BACKWARD;
        end

        sum_wide = {1'b0, speed_reg}
                 + (SW + 1)'(mul_p[zsd_pkg::FRAC_SHIFT +: zsd_pkg::INC_WIDTH]);
        sum_sat  = sum_wide[SW] ? zsd_pkg::SPEED_MAX : sum_wide[SW-1:0];
    end

    // sequencer and multiplier operand select
    always_comb
    begin
        state_next      = state_reg;
        speed_next      = speed_reg;
        dir_next        = dir_reg;
        quiet_next      = quiet_reg;
        stationary_next = stationary_reg;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                stationary_next = 1'b0;
                state_next      = ST_SCALE;
                if (smp_reg.sample_valid)
                begin
                    if (is_quiet)
                    begin
                        quiet_next = quiet_inc;
                        if (zero_hit)
                        begin
                            speed_next      = '0;
                            dir_next        = zsd_pkg::DIR_UNKNOWN;
                            stationary_next = 1'b1;
                        end
                    end
                    else
                    begin
                        quiet_next = '0;
                        if (dir_hit)
                        begin
                            dir_next = dir_new;
                        end
                        mul_en     = 1'b1;
                        mul_a      = MW'(smp_reg.magnitude);
                        mul_b      = MW'(step_gain_reg);
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(sum_reg);
                mul_b      = MW'(damping_reg);
                state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                speed_next = mul_p[zsd_pkg::FRAC_SHIFT +: SW];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(speed_reg);
                mul_b      = zsd_pkg::KMH_FACTOR;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                // speed * 18, then floor divide by 5 through the reciprocal
                mul_en     = 1'b1;
                mul_a      = MW'(mul_p[zsd_pkg::SCALED_WIDTH-1:0]);
                mul_b      = zsd_pkg::RECIP_FIVE;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            speed_reg      <= '0;
            dir_reg        <= zsd_pkg::DIR_UNKNOWN;
            quiet_reg      <= '0;
            stationary_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            speed_reg      <= speed_next;
            dir_reg        <= dir_next;
            quiet_reg      <= quiet_next;
            stationary_reg <= stationary_next;
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stationary_level_reg  <= zsd_pkg::STATIONARY_LEVEL_RST;
            still_count_limit_reg <= zsd_pkg::STILL_COUNT_LIMIT_RST;
            axis_level_reg        <= zsd_pkg::AXIS_LEVEL_RST;
            step_gain_reg         <= zsd_pkg::STEP_GAIN_RST;
            damping_reg           <= zsd_pkg::DAMPING_RST;
        end
        else if (cfg_we)
        begin
            unique case (zsd_pkg::cfg_index_t'(cfg_index))
                zsd_pkg::CFG_STATIONARY_LEVEL:
                    stationary_level_reg <= cfg_data[zsd_pkg::LEVEL_WIDTH-1:0];
                zsd_pkg::CFG_STILL_COUNT_LIMIT:
                    still_count_limit_reg <= cfg_data[zsd_pkg::COUNT_WIDTH-1:0];
                zsd_pkg::CFG_AXIS_LEVEL:
                    axis_level_reg <= cfg_data[zsd_pkg::LEVEL_WIDTH-1:0];
                zsd_pkg::CFG_STEP_GAIN:
                    step_gain_reg <= cfg_data[zsd_pkg::GAIN_WIDTH-1:0];
                zsd_pkg::CFG_DAMPING:
                    damping_reg <= cfg_data[zsd_pkg::GAIN_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            smp_reg <= in_data;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_sat;
        end
        if (done_fire)
        begin
            out_data_reg.speed_mps     <= speed_reg;
            out_data_reg.speed_kmh     <= mul_p[zsd_pkg::RECIP_SHIFT +: zsd_pkg::KMH_WIDTH];
            out_data_reg.heading       <= dir_reg;
            out_data_reg.is_stationary <= stationary_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == ST_DECIDE))
        else $error("accepted item did not start decode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.is_stationary) |->
            (out_data.speed_mps == '0 && out_data.heading == zsd_pkg::DIR_UNKNOWN))
        else $error("stationary item with nonzero speed or known heading");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.speed_kmh >= zsd_pkg::KMH_WIDTH'(out_data.speed_mps)))
        else $error("km/h below m/s");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending item");
`endif

endmodule

FILE: rtl/zsd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsd_mul
// Shared unsigned multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module zsd_mul
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [zsd_pkg::MUL_WIDTH-1:0]      a,
    input  logic [zsd_pkg::MUL_WIDTH-1:0]      b,
    output logic [2*zsd_pkg::MUL_WIDTH-1:0]    p
);

    logic [2*zsd_pkg::MUL_WIDTH-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

FILE: tb/zsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsd_checker
// Watches the sample and result channels and the register port of the speed
// and direction estimator. It keeps its own copy of the registers and of the
// speed, heading and quiet count state, predicts the result for every
// accepted sample and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module zsd_checker
    import zsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  sample_t                    in_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  result_t                    out_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                         fail_count,
    output int                         pending
);

    localparam longint unsigned KMH_NUM = 18;
    localparam longint unsigned KMH_DEN = 5;

    logic [LEVEL_WIDTH-1:0] cur_stationary;
    logic [COUNT_WIDTH-1:0] cur_limit;
    logic [LEVEL_WIDTH-1:0] cur_axis;
    logic [GAIN_WIDTH-1:0]  cur_gain;
    logic [GAIN_WIDTH-1:0]  cur_damping;

    logic [SPEED_WIDTH-1:0] speed_q;
    dir_t                   heading_q;
    logic [COUNT_WIDTH-1:0] quiet_cnt;

    result_t expected_results[$];

    // advances the motion state by one sample and returns its result
    function automatic result_t estimate_motion(input sample_t s);
        longint unsigned inc;
        longint unsigned sum;
        int              ax;
        int              ay;
        int              abs_x;
        int              abs_y;
        result_t         r;
        r = '0;
        if (s.sample_valid)
        begin
            if (s.magnitude < cur_stationary)
            begin
                if (quiet_cnt < cur_limit)
                    quiet_cnt = quiet_cnt + 1'b1;
                if (quiet_cnt >= cur_limit)
                begin
                    speed_q         = '0;
                    heading_q       = DIR_UNKNOWN;
                    r.is_stationary = 1'b1;
                end
            end
            else
            begin
                quiet_cnt = '0;
                inc = (64'(s.magnitude) * 64'(cur_gain)) >> FRAC_SHIFT;
                sum = 64'(speed_q) + inc;
                if (sum > 64'(SPEED_MAX))
                    sum = 64'(SPEED_MAX);
                speed_q = SPEED_WIDTH'((sum * 64'(cur_damping)) >> FRAC_SHIFT);
                ax    = int'($signed(s.accel_x));
                ay    = int'($signed(s.accel_y));
                abs_x = (ax < 0) ? -ax : ax;
                abs_y = (ay < 0) ? -ay : ay;
                if (abs_x > int'(cur_axis) || abs_y > int'(cur_axis))
                begin
                    if (abs_x > abs_y)
                        heading_q = (ax > 0) ? DIR_LEFT : DIR_RIGHT;
                    else
                        heading_q = (ay > 0) ? DIR_FORWARD : DIR_BACKWARD;
                end
            end
        end
        r.speed_mps = speed_q;
        r.speed_kmh = KMH_WIDTH'((64'(speed_q) * KMH_NUM) / KMH_DEN);
        r.heading   = heading_q;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        fail_count = fail_count + 1;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            fail_count = fail_count + 1;
            $display("%0t ns: result item with nothing expected, actual speed %0d",
                     $time, got.speed_mps);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.speed_mps !== want.speed_mps)
                flag_mismatch("speed_mps", want.speed_mps, got.speed_mps);
            if (got.speed_kmh !== want.speed_kmh)
                flag_mismatch("speed_kmh", want.speed_kmh, got.speed_kmh);
            if (got.heading !== want.heading)
                flag_mismatch("heading", want.heading, got.heading);
            if (got.is_stationary !== want.is_stationary)
                flag_mismatch("is_stationary", want.is_stationary, got.is_stationary);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_stationary = STATIONARY_LEVEL_RST;
            cur_limit      = STILL_COUNT_LIMIT_RST;
            cur_axis       = AXIS_LEVEL_RST;
            cur_gain       = STEP_GAIN_RST;
            cur_damping    = DAMPING_RST;
            speed_q        = '0;
            heading_q      = DIR_UNKNOWN;
            quiet_cnt      = '0;
            expected_results.delete();
            fail_count     = 0;
            pending        = 0;
        end
        else
        begin
            // results leave before this edge's sample is queued
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                expected_results.push_back(estimate_motion(in_data));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STATIONARY_LEVEL:  cur_stationary = cfg_data[LEVEL_WIDTH-1:0];
                    CFG_STILL_COUNT_LIMIT: cur_limit      = cfg_data[COUNT_WIDTH-1:0];
                    CFG_AXIS_LEVEL:        cur_axis       = cfg_data[LEVEL_WIDTH-1:0];
                    CFG_STEP_GAIN:         cur_gain       = cfg_data[GAIN_WIDTH-1:0];
                    CFG_DAMPING:           cur_damping    = cfg_data[GAIN_WIDTH-1:0];
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the speed and direction estimator: a short directed run over the
// field extremes, headings, ties and quiet count corner cases, then random
// samples under several register settings with random idling on both sides,
// a long output hold-off and a final stretch without idling.
// ----------------------------------------------------------------------------
module tb_top;

    import zsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES = 200;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    sample_t                    in_data;
    logic                       out_valid;
    logic                       out_ready;
    result_t                    out_data;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int                         fail_count;
    int                         pending;

    int cycles    = 0;
    int gap_pct   = 0;
    bit calm      = 1'b0;
    bit long_hold = 1'b0;
    int cur_level = 205;
    int cur_limit = 10;
    int cur_axis  = 410;
    int mag_floor = 0;
    int quiet_left = 0;

    zupt_speed_direction_estimator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    zsd_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < gap_pct)
            begin
                n = $urandom_range(1, 8);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic sample_t mk(input int mag, input int x, input int y, input bit v);
        sample_t s;
        s.magnitude    = MAG_WIDTH'(mag);
        s.accel_x      = ACC_WIDTH'(x);
        s.accel_y      = ACC_WIDTH'(y);
        s.sample_valid = v;
        return s;
    endfunction

    task automatic send(input sample_t s);
        int n;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            n = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_WIDTH'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_config(input int lvl, input int lim, input int axs,
                                input int gain, input int damp);
        settle();
        write_reg(CFG_STATIONARY_LEVEL, lvl);
        write_reg(CFG_STILL_COUNT_LIMIT, lim);
        write_reg(CFG_AXIS_LEVEL, axs);
        write_reg(CFG_STEP_GAIN, gain);
        write_reg(CFG_DAMPING, damp);
        cur_level  = lvl;
        cur_limit  = lim;
        cur_axis   = axs;
        quiet_left = 0;
    endtask

    function automatic int pick_accel();
        int x;
        x = int'($signed(16'($urandom)));
        case ($urandom_range(0, 7))
            0: x = -32768;
            1: x = 32767;
            2: x = 0;
            3: x = cur_axis + $urandom_range(0, 1);
            4: x = -(cur_axis + $urandom_range(0, 1));
            default: ;
        endcase
        return x;
    endfunction

    // quiet runs of random length around the limit, otherwise moving samples
    function automatic sample_t make_sample();
        int mag;
        int lo;
        int x;
        int y;
        bit v;
        v = ($urandom_range(0, 99) < 90);
        if (quiet_left > 0 && cur_level > 0)
        begin
            quiet_left = quiet_left - 1;
            mag = $urandom_range(0, cur_level - 1);
        end
        else
        begin
            if ($urandom_range(0, 99) < 15)
                quiet_left = $urandom_range(1, cur_limit + 2);
            lo  = (cur_level > mag_floor) ? cur_level : mag_floor;
            mag = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(lo, 32767);
        end
        if ($urandom_range(0, 19) == 0)
            mag = $urandom_range(0, 32767);
        x = pick_accel();
        y = pick_accel();
        case ($urandom_range(0, 7))
            0: y = x;
            1: y = -x;
            default: ;
        endcase
        return mk(mag, x, y, v);
    endfunction

    task automatic run_random(input int n);
        repeat (n) send(make_sample());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        gap_pct = 15;
        send(mk(32767, 32767, 0, 1'b1));
        send(mk(32767, -32768, 100, 1'b1));
        send(mk(32767, 0, 32767, 1'b1));
        send(mk(32767, 5, -32768, 1'b1));
        send(mk(205, 1000, -1000, 1'b1));     // equal axes, y decides
        send(mk(1000, 410, -410, 1'b1));      // axes at the level, heading kept
        repeat (5) send(mk(0, 0, 0, 1'b1));
        send(mk(32767, 32767, 32767, 1'b0));  // invalid in the middle of a quiet run
        repeat (4) send(mk(204, -1, 1, 1'b1));
        send(mk(0, 32767, -32768, 1'b1));     // tenth quiet sample: zero velocity
        send(mk(9000, -20000, 3000, 1'b1));
        repeat (5) send(mk(100, 0, 0, 1'b1));
        // limit dropped below the running count
        settle();
        write_reg(CFG_STILL_COUNT_LIMIT, 3);
        send(mk(50, 0, 0, 1'b1));
        // limit of zero: every quiet sample resets at once
        settle();
        write_reg(CFG_STILL_COUNT_LIMIT, 0);
        send(mk(20000, 0, -5000, 1'b1));
        send(mk(10, 0, 0, 1'b1));

        // random phases
        gap_pct = 20;
        apply_config(205, 10, 410, 6554, 64225);
        run_random(250);

        gap_pct = 40;
        apply_config(32767, 1, 0, 0, 0);
        run_random(120);

        // drive speed into saturation, no idling on either side
        gap_pct   = 0;
        mag_floor = 28000;
        apply_config(0, 255, 32767, 65535, 65535);
        run_random(700);
        mag_floor = 0;

        gap_pct = 30;
        apply_config(2000, 0, 1000, 30000, 60000);
        run_random(60);
        settle();
        long_hold = 1'b1;
        run_random(30);
        run_random(60);

        gap_pct = 25;
        repeat (2)
        begin
            apply_config($urandom_range(0, 4000), $urandom_range(0, 20),
                         $urandom_range(0, 8000), $urandom, $urandom_range(50000, 65535));
            run_random(150);
        end

        apply_config(205, 10, 410, 6554, 64225);
        calm = 1'b1;
        run_random(300);

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: zupt_speed_direction_estimator.f
rtl/zsd_pkg.sv
rtl/zsd_mul.sv
rtl/zupt_speed_direction_estimator.sv
tb/zsd_checker.sv
tb/tb_top.sv
